>>> rtl/core/ddwp_pkg.sv
// Shared constants, register codes and the configuration bundle of the depth back-projection block.
package ddwp_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COORD_CMP_W = 14;

    // Pipeline register stages; the last one is the output register.
    localparam int NSTAGE = 8;

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam logic [2:0] REG_ROT_ROW_0   = 3'd0;
    localparam logic [2:0] REG_ROT_ROW_1   = 3'd1;
    localparam logic [2:0] REG_ROT_ROW_2   = 3'd2;
    localparam logic [2:0] REG_TRANSLATION = 3'd3;
    localparam logic [2:0] REG_INV_FOCAL   = 3'd4;
    localparam logic [2:0] REG_PRINCIPAL   = 3'd5;
    localparam logic [2:0] REG_DEPTH_LIM   = 3'd6;

    localparam logic [59:0] RST_ROT_ROW_0 = 60'h000_0000_0004_0000;
    localparam logic [59:0] RST_ROT_ROW_1 = 60'h000_0040_0000_0000;
    localparam logic [59:0] RST_ROT_ROW_2 = 60'h400_0000_0000_0000;
    localparam logic [15:0] RST_DEPTH_MIN = 16'd400;
    localparam logic [15:0] RST_DEPTH_MAX = 16'd7000;

    typedef logic [NSTAGE:1] t_stage_en;

    typedef struct packed {
        logic [2:0][59:0] rot;
        logic [59:0]      trans;
        logic [23:0]      ify;
        logic [23:0]      ifx;
        logic [12:0]      cy;
        logic [12:0]      cx;
        logic [15:0]      dmax;
        logic [15:0]      dmin;
    } t_cfg;

endpackage

>>> rtl/core/ddwp_cfg.sv
// APB register file holding the pose, intrinsics and depth limits.
module ddwp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddwp_pkg::PADDR_W-1:0]  paddr,
    input  logic [ddwp_pkg::PDATA_W-1:0]  pwdata,
    output logic [ddwp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ddwp_pkg::t_cfg                o_cfg
);
    import ddwp_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;

    assign idx    = paddr[PADDR_W-1:3];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot[0] <= RST_ROT_ROW_0;
            r_cfg.rot[1] <= RST_ROT_ROW_1;
            r_cfg.rot[2] <= RST_ROT_ROW_2;
            r_cfg.trans  <= '0;
            r_cfg.ifx    <= '0;
            r_cfg.ify    <= '0;
            r_cfg.cx     <= '0;
            r_cfg.cy     <= '0;
            r_cfg.dmin   <= RST_DEPTH_MIN;
            r_cfg.dmax   <= RST_DEPTH_MAX;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_ROT_ROW_0:   r_cfg.rot[0] <= pwdata[59:0];
                REG_ROT_ROW_1:   r_cfg.rot[1] <= pwdata[59:0];
                REG_ROT_ROW_2:   r_cfg.rot[2] <= pwdata[59:0];
                REG_TRANSLATION: r_cfg.trans  <= pwdata[59:0];
                REG_INV_FOCAL: begin
                    r_cfg.ifx <= pwdata[23:0];
                    r_cfg.ify <= pwdata[47:24];
                end
                REG_PRINCIPAL: begin
                    r_cfg.cx <= pwdata[12:0];
                    r_cfg.cy <= pwdata[25:13];
                end
                REG_DEPTH_LIM: begin
                    r_cfg.dmin <= pwdata[15:0];
                    r_cfg.dmax <= pwdata[31:16];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ROT_ROW_0:   prdata = {4'd0, r_cfg.rot[0]};
            REG_ROT_ROW_1:   prdata = {4'd0, r_cfg.rot[1]};
            REG_ROT_ROW_2:   prdata = {4'd0, r_cfg.rot[2]};
            REG_TRANSLATION: prdata = {4'd0, r_cfg.trans};
            REG_INV_FOCAL:   prdata = {16'd0, r_cfg.ify, r_cfg.ifx};
            REG_PRINCIPAL:   prdata = {38'd0, r_cfg.cy, r_cfg.cx};
            REG_DEPTH_LIM:   prdata = {32'd0, r_cfg.dmax, r_cfg.dmin};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/ddwp_cam.sv
// Pipeline stages one to four: pinhole back-projection of a pixel to a camera point, x and y in Q.8, z in millimetres.
module ddwp_cam (
    input  logic                 i_clk,
    input  ddwp_pkg::t_stage_en  i_en,
    input  ddwp_pkg::t_cfg       i_cfg,
    input  logic [9:0]           i_column,
    input  logic [9:0]           i_row,
    input  logic [15:0]          i_depth_mm,
    output logic signed [38:0]   o_cam_x,
    output logic signed [38:0]   o_cam_y,
    output logic [15:0]          o_cam_z
);
    import ddwp_pkg::*;

    localparam logic signed [55:0] ROUND_Q8 = 56'sd65536;

    logic signed [13:0] r_dx, r_dy;
    logic signed [38:0] r_px, r_py;
    logic signed [55:0] r_pxd, r_pyd;
    logic signed [38:0] r_cx, r_cy;
    logic [15:0]        r_d1, r_d2, r_d3, r_d4;
    logic signed [55:0] n_xr, n_yr;

    // Offset from the principal point in half pixels.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_dx <= $signed({3'd0, i_column, 1'b0}) - $signed({1'b0, i_cfg.cx});
            r_dy <= $signed({3'd0, i_row, 1'b0}) - $signed({1'b0, i_cfg.cy});
            r_d1 <= i_depth_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_px <= r_dx * $signed({1'b0, i_cfg.ifx});
            r_py <= r_dy * $signed({1'b0, i_cfg.ify});
            r_d2 <= r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_pxd <= r_px * $signed({1'b0, r_d2});
            r_pyd <= r_py * $signed({1'b0, r_d2});
            r_d3  <= r_d2;
        end
    end

    // Round half up to Q.8 with a floor shift.
    assign n_xr = r_pxd + ROUND_Q8;
    assign n_yr = r_pyd + ROUND_Q8;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_cx <= n_xr[55:17];
            r_cy <= n_yr[55:17];
            r_d4 <= r_d3;
        end
    end

    assign o_cam_x = r_cx;
    assign o_cam_y = r_cy;
    assign o_cam_z = r_d4;

endmodule

>>> rtl/core/ddwp_xform.sv
// Pipeline stages five to eight: rigid pose transform, rounding and saturation to Q23.8.
module ddwp_xform (
    input  logic                 i_clk,
    input  ddwp_pkg::t_stage_en  i_en,
    input  ddwp_pkg::t_cfg       i_cfg,
    input  logic signed [38:0]   i_cam_x,
    input  logic signed [38:0]   i_cam_y,
    input  logic [15:0]          i_cam_z,
    output logic signed [31:0]   o_world_x,
    output logic signed [31:0]   o_world_y,
    output logic signed [31:0]   o_world_z
);
    import ddwp_pkg::*;

    localparam logic signed [61:0] ROUND_Q26 = 62'sd131072;
    localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

    logic signed [58:0] r_p0 [3];
    logic signed [58:0] r_p1 [3];
    logic signed [36:0] r_p2 [3];
    logic signed [61:0] r_sa [3];
    logic signed [61:0] r_sb [3];
    logic signed [43:0] r_rnd [3];
    logic signed [31:0] r_w [3];
    logic signed [61:0] n_acc [3];

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            for (int r = 0; r < 3; r++) begin
                r_p0[r] <= $signed(i_cfg.rot[r][19:0]) * i_cam_x;
                r_p1[r] <= $signed(i_cfg.rot[r][39:20]) * i_cam_y;
                r_p2[r] <= $signed(i_cfg.rot[r][59:40]) * $signed({1'b0, i_cam_z});
            end
        end
    end

    // The depth term is scaled from Q.0 to Q.8 and the translation to Q.26.
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            for (int r = 0; r < 3; r++) begin
                r_sa[r] <= 62'(r_p0[r]) + 62'(r_p1[r]);
                r_sb[r] <= (62'(r_p2[r]) <<< 8)
                         + (62'($signed(i_cfg.trans[r*20 +: 20])) <<< 26);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_acc[r] = r_sa[r] + r_sb[r] + ROUND_Q26;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            for (int r = 0; r < 3; r++) begin
                r_rnd[r] <= n_acc[r][61:18];
            end
        end
    end

    // In range when the bits above the 32-bit sign all match it.
    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            for (int r = 0; r < 3; r++) begin
                if ((&r_rnd[r][43:31]) || !(|r_rnd[r][43:31])) begin
                    r_w[r] <= r_rnd[r][31:0];
                end else if (r_rnd[r][43]) begin
                    r_w[r] <= SAT_MIN;
                end else begin
                    r_w[r] <= SAT_MAX;
                end
            end
        end
    end

    assign o_world_x = r_w[0];
    assign o_world_y = r_w[1];
    assign o_world_z = r_w[2];

endmodule

>>> rtl/core/depth_pixel_to_world_point.sv
// An accepted pixel word passes through the eight register stages to its world point word on the output.
// Throughput: one pixel word per cycle unless the output stalls; each stage holds one word.
// Pixels that fail the frame or depth checks travel on as empty slots that a stall squeezes out.
// Reset (synchronous, active low) empties the pipeline and restores the identity pose,
// zero translation, zero intrinsics and depth limits of 400 to 7000 millimetres.
module depth_pixel_to_world_point (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddwp_pkg::PADDR_W-1:0]  paddr,
    input  logic [ddwp_pkg::PDATA_W-1:0]  pwdata,
    output logic [ddwp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [9:0]                    i_column,
    input  logic [9:0]                    i_row,
    input  logic [15:0]                   i_depth_mm,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_red,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_world_x,
    output logic signed [31:0]            o_world_y,
    output logic signed [31:0]            o_world_z,
    output logic [7:0]                    o_point_blue,
    output logic [7:0]                    o_point_green,
    output logic [7:0]                    o_point_red
);
    import ddwp_pkg::*;

    t_cfg               cfg;
    t_stage_en          en;
    logic [NSTAGE:1]    r_valid;
    logic [23:0]        r_color [NSTAGE];
    logic               pixel_ok;
    logic signed [38:0] cam_x, cam_y;
    logic [15:0]        cam_z;

    ddwp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A pixel is kept when it lies inside the frame and its depth is a real reading
    // within the configured limits. A minimum above the maximum rejects every pixel.
    assign pixel_ok = ({4'd0, i_column} < COORD_CMP_W'(MAX_COLUMNS))
                   && ({4'd0, i_row} < COORD_CMP_W'(MAX_ROWS))
                   && (i_depth_mm != 16'd0)
                   && (i_depth_mm >= cfg.dmin)
                   && (i_depth_mm <= cfg.dmax);

    // Each stage loads when it is empty or when the stage after it moves on, so a
    // stall at the output backs up only as far as there are occupied stages and a
    // bubble inside the pipeline is squeezed out while the output waits.
    always_comb begin
        en[NSTAGE] = !r_valid[NSTAGE] || i_out_ready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[1]) begin
                r_valid[1] <= i_in_valid && pixel_ok;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // The colour rides alongside the arithmetic, one register per stage.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_color[0] <= {i_red, i_green, i_blue};
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (en[k+1]) begin
                r_color[k] <= r_color[k-1];
            end
        end
    end

    ddwp_cam u_cam (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_cfg      (cfg),
        .i_column   (i_column),
        .i_row      (i_row),
        .i_depth_mm (i_depth_mm),
        .o_cam_x    (cam_x),
        .o_cam_y    (cam_y),
        .o_cam_z    (cam_z)
    );

    ddwp_xform u_xform (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_cfg     (cfg),
        .i_cam_x   (cam_x),
        .i_cam_y   (cam_y),
        .i_cam_z   (cam_z),
        .o_world_x (o_world_x),
        .o_world_y (o_world_y),
        .o_world_z (o_world_z)
    );

    assign o_out_valid   = r_valid[NSTAGE];
    assign o_point_blue  = r_color[NSTAGE-1][7:0];
    assign o_point_green = r_color[NSTAGE-1][15:8];
    assign o_point_red   = r_color[NSTAGE-1][23:16];

endmodule
